FILE: rtl/mrr_pkg.sv
// ============================================================================
// mrr_pkg
// Shared types, constants and the CRC helper for the Modbus RTU request
// receiver.
// ============================================================================
`default_nettype none

package mrr_pkg;

    localparam int FRAME_MAX  = 256;
    localparam int CNT_W      = 9;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [7:0]  ADDR_BCAST = 8'hAA;
    localparam logic [7:0]  FC_MULTI   = 8'h10;
    localparam logic [7:0]  FC_FIX_LO  = 8'h01;
    localparam logic [7:0]  FC_FIX_HI  = 8'h06;
    localparam logic [7:0]  STA_RESET  = 8'h01;

    localparam logic [CNT_W-1:0] FIXED_LAST = CNT_W'(7);
    localparam logic [CNT_W-1:0] IDX_BCNT   = CNT_W'(6);
    localparam logic [CNT_W-1:0] MULTI_ADD  = CNT_W'(8);

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_ADDR    = 3'd1,
        ST_INFRAME = 3'd2,
        ST_OK      = 3'd3,
        ST_CRCBAD  = 3'd4,
        ST_BADFUNC = 3'd5,
        ST_TOOLONG = 3'd6
    } t_status;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       addr_hit;
        logic       fc_fixed;
        logic       fc_multi;
    } t_entry;

    // byte-wide reflected CRC-16 step, eight shifts unrolled
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mrr_front.sv
// ============================================================================
// mrr_front
// Accepts received bytes and tags each one with its address match and
// function code class before it enters the queue.
// ============================================================================
`default_nettype none

module mrr_front (
    input  wire logic            i_rx_valid,
    output logic                 o_rx_ready,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [7:0]      i_station,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output mrr_pkg::t_entry      o_entry
);

    assign o_rx_ready = !i_q_full;
    assign o_push     = i_rx_valid && !i_q_full;

    always_comb begin
        o_entry.data     = i_rx_byte;
        o_entry.addr_hit = (i_rx_byte == i_station) || (i_rx_byte == mrr_pkg::ADDR_BCAST);
        o_entry.fc_fixed = (i_rx_byte >= mrr_pkg::FC_FIX_LO) &&
                           (i_rx_byte <= mrr_pkg::FC_FIX_HI);
        o_entry.fc_multi = (i_rx_byte == mrr_pkg::FC_MULTI);
    end

endmodule

`default_nettype wire

FILE: rtl/mrr_fifo.sv
// ============================================================================
// mrr_fifo
// Short queue of classified bytes between the front and the frame engine.
// ============================================================================
`default_nettype none

module mrr_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mrr_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output mrr_pkg::t_entry      o_entry,
    output logic                 o_full,
    output logic                 o_empty
);

    mrr_pkg::t_entry r_mem [mrr_pkg::Q_DEPTH];
    logic [mrr_pkg::Q_AW-1:0] r_wptr, n_wptr;
    logic [mrr_pkg::Q_AW-1:0] r_rptr, n_rptr;
    logic [mrr_pkg::Q_AW:0]   r_count, n_count;

    assign o_full  = (r_count == (mrr_pkg::Q_AW+1)'(mrr_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (mrr_pkg::Q_AW+1)'(mrr_pkg::Q_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/mrr_back.sv
// ============================================================================
// mrr_back
// Frame engine: tracks the frame, runs the CRC, captures the header and
// registers one status item per byte.
// ============================================================================
`default_nettype none

module mrr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire mrr_pkg::t_entry i_entry,
    output logic                 o_pop,
    output logic                 o_res_valid,
    input  wire logic            i_res_ready,
    output logic [2:0]           o_rx_status,
    output logic [7:0]           o_function_code,
    output logic [15:0]          o_start_address,
    output logic [15:0]          o_quantity,
    output logic [7:0]           o_byte_index,
    output logic [7:0]           o_data_byte
);

    localparam int CW = mrr_pkg::CNT_W;

    logic                 r_mode, n_mode;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_exp, n_exp;
    logic [15:0]          r_crc, n_crc;
    logic [7:0]           r_fc, n_fc;
    logic [15:0]          r_sa, n_sa;
    logic [15:0]          r_qty, n_qty;
    logic                 r_fix, n_fix;
    logic                 r_mul, n_mul;
    logic                 r_ovalid;
    mrr_pkg::t_status     n_status;
    logic [CW-1:0]        n_idx;
    logic [CW-1:0]        cnt_inc;
    logic                 fix_now, mul_now;
    logic [7:0]           b;

    logic [2:0]           r_status;
    logic [7:0]           r_ofc, r_oidx, r_odata;
    logic [15:0]          r_osa, r_oqty;

    assign o_pop = !i_q_empty && (!r_ovalid || i_res_ready);
    assign b     = i_entry.data;

    always_comb begin
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_exp    = r_exp;
        n_crc    = r_crc;
        n_fc     = r_fc;
        n_sa     = r_sa;
        n_qty    = r_qty;
        n_fix    = r_fix;
        n_mul    = r_mul;
        n_status = mrr_pkg::ST_IGNORED;
        n_idx    = '0;
        cnt_inc  = r_cnt + 1'b1;
        fix_now  = (cnt_inc == CW'(1)) ? i_entry.fc_fixed : r_fix;
        mul_now  = (cnt_inc == CW'(1)) ? i_entry.fc_multi : r_mul;

        if (!r_mode) begin
            if (i_entry.addr_hit) begin
                n_mode   = 1'b1;
                n_cnt    = '0;
                n_fc     = '0;
                n_sa     = '0;
                n_qty    = '0;
                n_crc    = mrr_pkg::crc_fold(mrr_pkg::CRC_SEED, b);
                n_status = mrr_pkg::ST_ADDR;
            end
        end else begin
            n_cnt    = cnt_inc;
            n_idx    = cnt_inc;
            n_crc    = mrr_pkg::crc_fold(r_crc, b);
            n_status = mrr_pkg::ST_INFRAME;
            case (cnt_inc)
                CW'(1): begin
                    n_fc  = b;
                    n_fix = i_entry.fc_fixed;
                    n_mul = i_entry.fc_multi;
                end
                CW'(2):  n_sa[15:8]  = b;
                CW'(3):  n_sa[7:0]   = b;
                CW'(4):  n_qty[15:8] = b;
                CW'(5):  n_qty[7:0]  = b;
                default: ;
            endcase

            if (cnt_inc < mrr_pkg::FIXED_LAST) begin
                if (fix_now) begin
                    n_exp = mrr_pkg::FIXED_LAST;
                end else if (mul_now) begin
                    if (cnt_inc == mrr_pkg::IDX_BCNT) begin
                        n_exp = CW'(b) + mrr_pkg::MULTI_ADD;
                        if ({1'b0, n_exp} > (CW+1)'(mrr_pkg::FRAME_MAX)) begin
                            n_status = mrr_pkg::ST_TOOLONG;
                            n_mode   = 1'b0;
                            n_cnt    = '0;
                        end
                    end
                end else begin
                    n_status = mrr_pkg::ST_BADFUNC;
                    n_mode   = 1'b0;
                    n_cnt    = '0;
                end
            end else if ({1'b0, cnt_inc} >= (CW+1)'(mrr_pkg::FRAME_MAX)) begin
                n_status = mrr_pkg::ST_TOOLONG;
                n_mode   = 1'b0;
                n_cnt    = '0;
            end else if (cnt_inc == r_exp) begin
                n_status = (n_crc == 16'h0000) ? mrr_pkg::ST_OK : mrr_pkg::ST_CRCBAD;
                n_mode   = 1'b0;
                n_cnt    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_cnt    <= '0;
            r_exp    <= mrr_pkg::FIXED_LAST;
            r_crc    <= mrr_pkg::CRC_SEED;
            r_fc     <= '0;
            r_sa     <= '0;
            r_qty    <= '0;
            r_fix    <= 1'b0;
            r_mul    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_exp  <= n_exp;
                r_crc  <= n_crc;
                r_fc   <= n_fc;
                r_sa   <= n_sa;
                r_qty  <= n_qty;
                r_fix  <= n_fix;
                r_mul  <= n_mul;
            end
            if (o_pop) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_ofc    <= n_fc;
            r_osa    <= n_sa;
            r_oqty   <= n_qty;
            r_oidx   <= n_idx[7:0];
            r_odata  <= b;
        end
    end

    assign o_res_valid     = r_ovalid;
    assign o_rx_status     = r_status;
    assign o_function_code = r_ofc;
    assign o_start_address = r_osa;
    assign o_quantity      = r_oqty;
    assign o_byte_index    = r_oidx;
    assign o_data_byte     = r_odata;

    a_wait_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mode |-> (r_cnt == '0))
        else $error("counter not zero while waiting for address");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cnt} < (CW+1)'(mrr_pkg::FRAME_MAX))
        else $error("byte counter passed frame limit");
    a_ignored_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_rx_status == mrr_pkg::ST_IGNORED ||
                         o_rx_status == mrr_pkg::ST_ADDR)) |-> (o_byte_index == 8'd0))
        else $error("address-phase item with nonzero index");

endmodule

`default_nettype wire

FILE: rtl/modbus_rtu_request_receiver_top.sv
// ============================================================================
// modbus_rtu_request_receiver_top
// Modbus RTU request receiver: frame detection, header capture and CRC-16.
// ============================================================================
// Takes one received byte per clock while the queue is not full and returns
// one status item per byte, in order. A byte is tagged on entry (address
// match, function code class), held in a 4-entry queue, then processed by
// the frame engine, which folds it into the CRC combinationally and loads the
// registered result. With the result side ready, throughput is one byte per
// cycle, each byte passing the queue and then the result register. The queue
// absorbs up to four bytes while the result side stalls. station_address
// resets to 1 and should only be written while no bytes are in flight.
`default_nettype none

module modbus_rtu_request_receiver_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [2:0]       o_rx_status,
    output logic [7:0]       o_function_code,
    output logic [15:0]      o_start_address,
    output logic [15:0]      o_quantity,
    output logic [7:0]       o_byte_index,
    output logic [7:0]       o_data_byte
);

    logic [7:0]      r_station;
    logic            push, pop, q_full, q_empty;
    mrr_pkg::t_entry f_entry, q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= mrr_pkg::STA_RESET;
        end else if (i_cfg_we) begin
            r_station <= i_cfg_data;
        end
    end

    mrr_front u_front (
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_station  (r_station),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (f_entry)
    );

    mrr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mrr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_entry         (q_entry),
        .o_pop           (pop),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_rx_status     (o_rx_status),
        .o_function_code (o_function_code),
        .o_start_address (o_start_address),
        .o_quantity      (o_quantity),
        .o_byte_index    (o_byte_index),
        .o_data_byte     (o_data_byte)
    );

endmodule

`default_nettype wire

FILE: verif/mrr_result_checker.sv
// ----------------------------------------------------------------------------
// mrr_result_checker
// Watches the byte and status channels of the Modbus RTU request receiver.
// Keeps its own copy of the frame state, address register and CRC, predicts
// one status item per accepted byte and compares each returned item with the
// oldest prediction.
// ----------------------------------------------------------------------------
module mrr_result_checker
    import mrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_rx_status,
    input  logic [7:0]  i_function_code,
    input  logic [15:0] i_start_address,
    input  logic [15:0] i_quantity,
    input  logic [7:0]  i_byte_index,
    input  logic [7:0]  i_data_byte,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status     status;
        logic [7:0]  fc;
        logic [15:0] start;
        logic [15:0] qty;
        logic [7:0]  pos;
        logic [7:0]  data;
    } t_frame_status;

    t_frame_status expected_status[$];
    int mismatches = 0;

    // shadow of the receiver state
    logic [7:0]       own_addr;
    logic             rcv_active;
    logic [CNT_W-1:0] frame_idx;
    logic [CNT_W-1:0] last_idx;
    logic [15:0]      crc_acc;
    logic [7:0]       hdr_fc;
    logic [15:0]      hdr_start;
    logic [15:0]      hdr_qty;

    assign o_fail_count = mismatches;

    // reflected CRC-16, one input bit per step
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic t_frame_status decode_byte(input logic [7:0] b);
        t_frame_status r;
        t_status st;
        logic [CNT_W-1:0] pos;
        st  = ST_IGNORED;
        pos = '0;
        if (!rcv_active) begin
            if (b == own_addr || b == ADDR_BCAST) begin
                rcv_active = 1'b1;
                frame_idx  = '0;
                hdr_fc     = '0;
                hdr_start  = '0;
                hdr_qty    = '0;
                crc_acc    = crc16_byte(CRC_SEED, b);
                st         = ST_ADDR;
            end
        end else begin
            frame_idx = frame_idx + 1'b1;
            pos       = frame_idx;
            crc_acc   = crc16_byte(crc_acc, b);
            case (pos)
                1: hdr_fc          = b;
                2: hdr_start[15:8] = b;
                3: hdr_start[7:0]  = b;
                4: hdr_qty[15:8]   = b;
                5: hdr_qty[7:0]    = b;
                default: ;
            endcase
            st = ST_INFRAME;
            if (pos < FIXED_LAST) begin
                if (hdr_fc >= FC_FIX_LO && hdr_fc <= FC_FIX_HI) begin
                    last_idx = FIXED_LAST;
                end else if (hdr_fc == FC_MULTI) begin
                    if (pos == IDX_BCNT) begin
                        last_idx = {1'b0, b} + MULTI_ADD;
                        if (last_idx > FRAME_MAX) begin
                            st = ST_TOOLONG;
                        end
                    end
                end else begin
                    st = ST_BADFUNC;
                end
            end else if (pos >= FRAME_MAX) begin
                st = ST_TOOLONG;
            end else if (pos == last_idx) begin
                st = (crc_acc == 16'h0000) ? ST_OK : ST_CRCBAD;
            end
            if (st != ST_INFRAME) begin
                rcv_active = 1'b0;
                frame_idx  = '0;
            end
        end
        r.status = st;
        r.fc     = hdr_fc;
        r.start  = hdr_start;
        r.qty    = hdr_qty;
        r.pos    = pos[7:0];
        r.data   = b;
        return r;
    endfunction

    function automatic void show_item(input string tag, input t_frame_status s);
        $display("%s st %0d fc %02h sa %04h qty %04h idx %0d data %02h",
                 tag, s.status, s.fc, s.start, s.qty, s.pos, s.data);
    endfunction

    always @(posedge i_clk) begin
        t_frame_status want;
        t_frame_status got;
        logic          bad;
        if (!i_rst_n) begin
            own_addr   = STA_RESET;
            rcv_active = 1'b0;
            frame_idx  = '0;
            last_idx   = FIXED_LAST;
            crc_acc    = CRC_SEED;
            hdr_fc     = '0;
            hdr_start  = '0;
            hdr_qty    = '0;
            expected_status.delete();
        end else begin
            if (i_cfg_we) own_addr = i_cfg_data;
            if (i_rx_valid && i_rx_ready) expected_status.push_back(decode_byte(i_rx_byte));
            if (i_res_valid && i_res_ready) begin
                got.status = t_status'(i_rx_status);
                got.fc     = i_function_code;
                got.start  = i_start_address;
                got.qty    = i_quantity;
                got.pos    = i_byte_index;
                got.data   = i_data_byte;
                if (expected_status.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("[%0t] status item with none pending", $realtime);
                        show_item("  got:", got);
                    end
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    bad  = (got.status !== want.status) || (got.fc !== want.fc) ||
                           (got.start !== want.start) || (got.qty !== want.qty) ||
                           (got.pos !== want.pos) || (got.data !== want.data);
                    if (bad) begin
                        if (mismatches < 10) begin
                            $display("[%0t] mismatch", $realtime);
                            show_item("  exp:", want);
                            show_item("  got:", got);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= expected_status.size();
    end

endmodule

FILE: verif/tb_modbus_rtu_request_receiver_top.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_request_receiver_top
// Drives byte streams into the Modbus RTU request receiver: a few directed
// frames, then random well-formed requests, corrupted and cut frames and line
// noise under several station addresses, with random stalls on both channels.
// The checker beside the block predicts and compares every status item.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_request_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 170;

    typedef logic [7:0] t_byte_seq[$];

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_data  = '0;
    logic        rx_valid  = 1'b0;
    logic [7:0]  rx_byte   = '0;
    logic        res_ready = 1'b0;
    logic        rx_ready;
    logic        res_valid;
    logic [2:0]  rx_status;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;

    int         failures;
    int         pending;
    int         cycles    = 0;
    int         sent      = 0;
    bit         calm      = 1'b0;
    logic [7:0] station   = STA_RESET;
    logic [7:0] settings[5];

    always #10 clk = ~clk;

    modbus_rtu_request_receiver_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_rx_valid      (rx_valid),
        .o_rx_ready      (rx_ready),
        .i_rx_byte       (rx_byte),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_rx_status     (rx_status),
        .o_function_code (function_code),
        .o_start_address (start_address),
        .o_quantity      (quantity),
        .o_byte_index    (byte_index),
        .o_data_byte     (data_byte)
    );

    mrr_result_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_rx_valid      (rx_valid),
        .i_rx_ready      (rx_ready),
        .i_rx_byte       (rx_byte),
        .i_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .i_rx_status     (rx_status),
        .i_function_code (function_code),
        .i_start_address (start_address),
        .i_quantity      (quantity),
        .i_byte_index    (byte_index),
        .i_data_byte     (data_byte),
        .o_fail_count    (failures),
        .o_pending       (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** modbus_rtu_request_receiver_top: FAILED **");
            $finish;
        end
    end

    always @(posedge clk) begin
        res_ready <= calm || ($urandom_range(99) >= 26);
    end

    // Modbus CRC over a whole frame, byte-wise form
    function automatic logic [15:0] frame_crc(input t_byte_seq fr);
        logic [15:0] c;
        c = CRC_SEED;
        foreach (fr[i]) begin
            c = c ^ {8'h00, fr[i]};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // valid stays up between back-to-back items; it drops only while idle cycles are inserted
    task automatic put_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 26) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
    endtask

    // hold off the byte side until every status item has come back
    task automatic settle();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_station(input logic [7:0] a);
        cfg_we   <= 1'b1;
        cfg_data <= a;
        @(posedge clk);
        cfg_we   <= 1'b0;
        station  = a;
    endtask

    // bad function codes stop after index 1, oversize byte counts after index 6
    task automatic send_request(input logic [7:0] addr, input logic [7:0] fc, input int bcnt,
                                input bit spoil, input int cut);
        t_byte_seq   fr;
        logic [15:0] c;
        int          stop;
        fr = {};
        fr.push_back(addr);
        fr.push_back(fc);
        repeat (4) fr.push_back(8'($urandom_range(255)));
        if (fc == FC_MULTI) begin
            fr.push_back(bcnt[7:0]);
            repeat (bcnt) fr.push_back(8'($urandom_range(255)));
        end
        c = frame_crc(fr);
        if (spoil) c = c ^ (16'h0001 << $urandom_range(15));
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
        stop = fr.size();
        if (fc != FC_MULTI && (fc < FC_FIX_LO || fc > FC_FIX_HI))
            stop = 2;
        else if (fc == FC_MULTI && bcnt + int'(MULTI_ADD) > FRAME_MAX)
            stop = int'(IDX_BCNT) + 1;
        if (cut > 0 && cut < stop) stop = cut;
        for (int k = 0; k < stop; k++) put_byte(fr[k]);
        sent += stop;
    endtask

    function automatic logic [7:0] pick_addr();
        return $urandom_range(1) ? station : ADDR_BCAST;
    endfunction

    function automatic logic [7:0] pick_fc();
        int r;
        r = $urandom_range(6);
        return (r == 6) ? FC_MULTI : 8'(r + 1);
    endfunction

    function automatic logic [7:0] pick_bad_fc();
        logic [7:0] f;
        f = 8'($urandom_range(255));
        while (f == FC_MULTI || (f >= FC_FIX_LO && f <= FC_FIX_HI)) f = 8'($urandom_range(255));
        return f;
    endfunction

    function automatic int pick_bcnt();
        return ($urandom_range(9) < 8) ? $urandom_range(12) : $urandom_range(60);
    endfunction

    task automatic random_traffic(input int target);
        int r;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 55)
                send_request(pick_addr(), pick_fc(), pick_bcnt(), 1'b0, 0);
            else if (r < 70)
                send_request(pick_addr(), pick_fc(), pick_bcnt(), 1'b1, 0);
            else if (r < 80)
                send_request(pick_addr(), pick_bad_fc(), 0, 1'b0, 0);
            else if (r < 88)
                send_request(pick_addr(), pick_fc(), pick_bcnt(), 1'b0, $urandom_range(1, 6));
            else if (r < 98)
                repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(255)));
            else
                settle();
        end
    endtask

    initial begin
        settings = '{8'h00, 8'hFF, ADDR_BCAST, 8'h00, STA_RESET};
        settings[3] = 8'($urandom_range(255));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_station(STA_RESET);

        // directed: ignored byte, fixed frame, bad function, oversize count,
        // broadcast multi-write with corrupted CRC
        put_byte(8'h00);
        send_request(station, FC_FIX_HI, 0, 1'b0, 0);
        send_request(station, 8'h00, 0, 1'b0, 0);
        send_request(ADDR_BCAST, FC_MULTI, 255, 1'b0, 0);
        send_request(ADDR_BCAST, FC_MULTI, 0, 1'b1, 0);

        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            set_station(settings[ph]);
            calm = (ph == 3);
            if (ph == 1) send_request(pick_addr(), FC_MULTI, FRAME_MAX - 9, 1'b0, 0);
            if (ph == 2) begin
                // frame runs into the size limit by count, then by declared length
                send_request(pick_addr(), FC_MULTI, FRAME_MAX - 8, 1'b0, 0);
                send_request(pick_addr(), FC_MULTI, FRAME_MAX - 7, 1'b0, 0);
            end
            random_traffic((ph + 1) * PHASE_ITEMS);
        end
        calm = 1'b0;

        settle();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("** modbus_rtu_request_receiver_top: PASSED **");
        else
            $display("** modbus_rtu_request_receiver_top: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mrr_pkg.sv
rtl/mrr_front.sv
rtl/mrr_fifo.sv
rtl/mrr_back.sv
rtl/modbus_rtu_request_receiver_top.sv
verif/mrr_result_checker.sv
verif/tb_modbus_rtu_request_receiver_top.sv
